// ----- rtl/hvm_pkg.sv -----
// shared constants, codes and types of the haptic vibration mixer
package hvm_pkg;

   localparam int CONTROLLERS_DEF   = 4;
   localparam int MOTORS_DEF        = 2;
   localparam int TRACK_SAMPLES_DEF = 64;

   localparam int LEVEL_W      = 13;
   localparam int FULL_LEVEL   = 4096;
   localparam int PERIOD_W     = 20;
   localparam int PERIOD_RESET = 6250;
   localparam int DIV_W        = 22;
   localparam int DIV_CNT_W    = 5;

   localparam logic [2:0] OP_ENABLE   = 3'd0;
   localparam logic [2:0] OP_STRENGTH = 3'd1;
   localparam logic [2:0] OP_MAPPING  = 3'd2;
   localparam logic [2:0] OP_SAMPLE   = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;

   localparam logic [3:0] MAP_OFF = 4'hF;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SAMP_MUL,
      ST_SAMP_MERGE,
      ST_DIV_TIME,
      ST_CLEAR,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef logic [LEVEL_W-1:0] level_type;

endpackage

// ----- rtl/haptic_vibration_mixer_core.sv -----
// top level of the haptic vibration mixer: sequencer, shared divider and track ring memory
//
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    op, indexes, level, scale, offset, time delta
// rsp      out        rsp_valid/rsp_ready    physical index, motor, drive level, last
// csr      in         csr_valid/csr_ready    sample period (always ready)
//
// ops 0 to 2 complete in the idle state; a track sample runs a multiply and ring read state, then a merge state
// a tick runs the shared restoring divider, which also folds the step count
// into the ring length, then min(n, TRACK_SAMPLES) row clears, one ring read,
// then CONTROLLERS*MOTORS results at one per cycle while rsp is not stalled
// after reset every ring row is swept to zero with req_ready low
// a stalled rsp holds the result register and the emit walk; req waits until idle
module haptic_vibration_mixer_core #(
   parameter int CONTROLLERS   = hvm_pkg::CONTROLLERS_DEF,
   parameter int MOTORS        = hvm_pkg::MOTORS_DEF,
   parameter int TRACK_SAMPLES = hvm_pkg::TRACK_SAMPLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_op,
   input  logic [2:0]                    req_virtual_index,
   input  logic [1:0]                    req_motor_index,
   input  logic                          req_enable_flag,
   input  logic signed [3:0]             req_physical_target,
   input  logic signed [15:0]            req_level_in,
   input  logic [15:0]                   req_scale,
   input  logic [9:0]                    req_sample_offset,
   input  logic [15:0]                   req_time_delta,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_physical_index,
   output logic [1:0]                    rsp_motor_out,
   output logic [hvm_pkg::LEVEL_W-1:0]   rsp_drive_level,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hvm_pkg::PERIOD_W-1:0]  csr_sample_period
);

   localparam int LW    = hvm_pkg::LEVEL_W;
   localparam int DW    = hvm_pkg::DIV_W;
   localparam int PRW   = hvm_pkg::PERIOD_W;
   localparam int ENT   = CONTROLLERS * MOTORS;
   localparam int ROW_W = ENT * LW;
   localparam int CIW   = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
   localparam int MIW   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam int EW    = (ENT > 1) ? $clog2(ENT) : 1;
   localparam int PW    = $clog2(TRACK_SAMPLES);
   localparam int LCW   = $clog2(TRACK_SAMPLES + 1);

   hvm_pkg::state_type state_ff, state_in;

   logic [ROW_W-1:0] track_mem [TRACK_SAMPLES];
   logic [ROW_W-1:0] rd_data_ff;

   logic                enabled_ff  [CONTROLLERS];
   logic [3:0]          mapping_ff  [CONTROLLERS];
   hvm_pkg::level_type  strength_ff [ENT];
   logic [PRW-1:0]      period_ff;
   logic [PRW-1:0]      elapsed_ff;
   logic [PW-1:0]       pos_ff;
   logic [PW-1:0]       col_ff;
   logic [LCW-1:0]      left_ff;
   logic [DW-1:0]       div_quo_ff;
   logic [PRW-1:0]      div_rem_ff;
   logic [PW-1:0]       nmod_ff;
   logic [hvm_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [CIW-1:0]      p_ff;
   logic [MIW-1:0]      me_ff;

   // item fields kept for the track sample
   logic [CIW-1:0]      it_v_ff;
   logic [MIW-1:0]      it_m_ff;
   logic signed [15:0]  it_level_ff;
   logic [15:0]         it_scale_ff;
   logic [PW-1:0]       it_off_ff;
   logic signed [32:0]  prod_ff;
   logic [PW-1:0]       slot_ff;

   logic                rsp_valid_ff;
   logic [2:0]          rsp_phys_ff;
   logic [1:0]          rsp_motor_ff;
   hvm_pkg::level_type  rsp_level_ff;
   logic                rsp_last_ff;

   function automatic logic [EW-1:0] entry_idx(input int c, input int m);
      entry_idx = EW'(c * MOTORS + m);
   endfunction

   // request decode
   logic accept, v_ok, m_ok, t_ok, off_ok;
   logic [CIW-1:0] v_idx;
   logic [MIW-1:0] m_idx;
   assign accept = req_valid && req_ready;
   assign v_idx  = req_virtual_index[CIW-1:0];
   assign m_idx  = req_motor_index[MIW-1:0];
   assign v_ok   = 32'(req_virtual_index) < CONTROLLERS;
   assign m_ok   = 32'(req_motor_index) < MOTORS;
   assign t_ok   = req_physical_target[3] || (32'(req_physical_target[2:0]) < CONTROLLERS);
   assign off_ok = 32'(req_sample_offset) < TRACK_SAMPLES;

   // strength clamp
   hvm_pkg::level_type clamp_in;
   always_comb begin
      if (req_level_in <= 16'sd0) begin
         clamp_in = '0;
      end else if (req_level_in >= 16'(hvm_pkg::FULL_LEVEL)) begin
         clamp_in = LW'(hvm_pkg::FULL_LEVEL);
      end else begin
         clamp_in = req_level_in[LW-1:0];
      end
   end

   // remap with swap
   logic [3:0] map_new [CONTROLLERS];
   always_comb begin
      logic found;
      found = 1'b0;
      for (int c = 0; c < CONTROLLERS; c++) map_new[c] = mapping_ff[c];
      if (!req_physical_target[3]) begin
         for (int c = 0; c < CONTROLLERS; c++) begin
            if (!found && mapping_ff[c] == {1'b0, req_physical_target[2:0]}) begin
               map_new[c] = mapping_ff[v_idx];
               found = 1'b1;
            end
         end
         map_new[v_idx] = {1'b0, req_physical_target[2:0]};
      end else begin
         map_new[v_idx] = hvm_pkg::MAP_OFF;
      end
   end

   // shared restoring divider step
   logic [PRW-1:0] divisor;
   logic [PRW:0]   trial;
   logic           div_ge;
   logic [PRW-1:0] rem_next;
   logic [DW-1:0]  quo_next;
   logic [PW:0]    nmod_sum;
   logic [PW-1:0]  nmod_next;
   logic [PW:0]    pos_sum;
   logic [PW-1:0]  pos_next;
   logic           div_done;
   always_comb begin
      divisor  = (period_ff == '0) ? PRW'(1) : period_ff;
      trial    = {div_rem_ff, div_quo_ff[DW-1]};
      div_ge   = trial >= {1'b0, divisor};
      rem_next = div_ge ? PRW'(trial - {1'b0, divisor}) : trial[PRW-1:0];
      quo_next = {div_quo_ff[DW-2:0], div_ge};
      // step count modulo ring length, built msb first beside the quotient
      nmod_sum  = {nmod_ff, div_ge};
      nmod_next = (32'(nmod_sum) >= TRACK_SAMPLES) ? PW'(32'(nmod_sum) - TRACK_SAMPLES)
                                                   : nmod_sum[PW-1:0];
      pos_sum   = {1'b0, pos_ff} + {1'b0, nmod_next};
      pos_next  = (32'(pos_sum) >= TRACK_SAMPLES) ? PW'(32'(pos_sum) - TRACK_SAMPLES)
                                                  : pos_sum[PW-1:0];
   end
   assign div_done = div_cnt_ff == hvm_pkg::DIV_CNT_W'(DW - 1);

   // slot of a track sample
   logic [PW:0]    slot_sum;
   logic [PW-1:0]  slot_comb;
   always_comb begin
      slot_sum  = {1'b0, pos_ff} + {1'b0, it_off_ff} + (PW+1)'(1);
      slot_comb = (32'(slot_sum) >= TRACK_SAMPLES) ? PW'(32'(slot_sum) - TRACK_SAMPLES)
                                                   : slot_sum[PW-1:0];
   end

   // merge of a scaled sample
   hvm_pkg::level_type samp_val, samp_old;
   logic [ROW_W-1:0]   merge_row;
   logic [EW-1:0]      samp_idx;
   always_comb begin
      samp_idx = entry_idx(int'(it_v_ff), int'(it_m_ff));
      if (prod_ff <= 33'sd0) begin
         samp_val = '0;
      end else if (prod_ff[32:12] >= 21'(hvm_pkg::FULL_LEVEL)) begin
         samp_val = LW'(hvm_pkg::FULL_LEVEL);
      end else begin
         samp_val = prod_ff[12+LW-1:12];
      end
      samp_old  = rd_data_ff[samp_idx*LW +: LW];
      merge_row = rd_data_ff;
      merge_row[samp_idx*LW +: LW] = samp_val;
   end

   // level for the result being walked: highest enabled virtual controller wins
   hvm_pkg::level_type emit_level;
   logic               emit_last;
   always_comb begin
      logic               hit;
      logic [CIW-1:0]     src;
      hvm_pkg::level_type s_lv, t_lv;
      hit = 1'b0;
      src = '0;
      for (int c = 0; c < CONTROLLERS; c++) begin
         if (enabled_ff[c] && mapping_ff[c] == 4'(p_ff)) begin
            hit = 1'b1;
            src = CIW'(c);
         end
      end
      s_lv = strength_ff[entry_idx(int'(src), int'(me_ff))];
      t_lv = rd_data_ff[entry_idx(int'(src), int'(me_ff))*LW +: LW];
      emit_level = !hit ? '0 : ((s_lv > t_lv) ? s_lv : t_lv);
      emit_last  = (32'(p_ff) == CONTROLLERS - 1) && (32'(me_ff) == MOTORS - 1);
   end

   logic emit_load;
   assign emit_load = (state_ff == hvm_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hvm_pkg::ST_INIT: begin
            if (32'(col_ff) == TRACK_SAMPLES - 1) state_in = hvm_pkg::ST_IDLE;
         end
         hvm_pkg::ST_IDLE: begin
            if (accept && req_op == hvm_pkg::OP_TICK) begin
               state_in = hvm_pkg::ST_DIV_TIME;
            end else if (accept && req_op == hvm_pkg::OP_SAMPLE && v_ok && m_ok && off_ok) begin
               state_in = hvm_pkg::ST_SAMP_MUL;
            end
         end
         hvm_pkg::ST_SAMP_MUL:   state_in = hvm_pkg::ST_SAMP_MERGE;
         hvm_pkg::ST_SAMP_MERGE: state_in = hvm_pkg::ST_IDLE;
         hvm_pkg::ST_DIV_TIME: begin
            if (div_done) state_in = (quo_next == '0) ? hvm_pkg::ST_READ : hvm_pkg::ST_CLEAR;
         end
         hvm_pkg::ST_CLEAR: begin
            if (left_ff == LCW'(1)) state_in = hvm_pkg::ST_READ;
         end
         hvm_pkg::ST_READ: state_in = hvm_pkg::ST_EMIT;
         hvm_pkg::ST_EMIT: begin
            if (emit_load && emit_last) state_in = hvm_pkg::ST_IDLE;
         end
         default: state_in = hvm_pkg::ST_IDLE;
      endcase
   end

   // memory port controls
   logic             mem_we;
   logic [PW-1:0]    mem_waddr;
   logic [ROW_W-1:0] mem_wdata;
   logic [PW-1:0]    mem_raddr;
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = col_ff;
      mem_wdata = '0;
      mem_raddr = pos_ff;
      case (state_ff)
         hvm_pkg::ST_INIT, hvm_pkg::ST_CLEAR: mem_we = 1'b1;
         hvm_pkg::ST_SAMP_MUL: mem_raddr = slot_comb;
         hvm_pkg::ST_SAMP_MERGE: begin
            mem_we    = samp_val > samp_old;
            mem_waddr = slot_ff;
            mem_wdata = merge_row;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) track_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= track_mem[mem_raddr];
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hvm_pkg::ST_INIT;
         period_ff    <= PRW'(hvm_pkg::PERIOD_RESET);
         elapsed_ff   <= '0;
         pos_ff       <= '0;
         col_ff       <= '0;
         left_ff      <= '0;
         div_cnt_ff   <= '0;
         p_ff         <= '0;
         me_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CONTROLLERS; c++) begin
            enabled_ff[c] <= 1'b0;
            mapping_ff[c] <= 4'(c);
         end
         for (int e = 0; e < ENT; e++) strength_ff[e] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) period_ff <= csr_sample_period;
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            hvm_pkg::ST_INIT: begin
               col_ff <= (32'(col_ff) == TRACK_SAMPLES - 1) ? '0 : col_ff + PW'(1);
            end
            hvm_pkg::ST_IDLE: begin
               if (accept && v_ok) begin
                  if (req_op == hvm_pkg::OP_ENABLE) enabled_ff[v_idx] <= req_enable_flag;
                  if (req_op == hvm_pkg::OP_STRENGTH && m_ok) begin
                     strength_ff[entry_idx(int'(v_idx), int'(m_idx))] <= clamp_in;
                  end
                  if (req_op == hvm_pkg::OP_MAPPING && t_ok) begin
                     for (int c = 0; c < CONTROLLERS; c++) mapping_ff[c] <= map_new[c];
                  end
               end
               div_cnt_ff <= '0;
               p_ff       <= '0;
               me_ff      <= '0;
            end
            hvm_pkg::ST_DIV_TIME: begin
               if (div_done) begin
                  div_cnt_ff <= '0;
                  elapsed_ff <= rem_next;
                  pos_ff     <= pos_next;
                  col_ff     <= pos_ff;
                  left_ff    <= (quo_next >= DW'(TRACK_SAMPLES)) ? LCW'(TRACK_SAMPLES)
                                                                 : quo_next[LCW-1:0];
               end else begin
                  div_cnt_ff <= div_cnt_ff + hvm_pkg::DIV_CNT_W'(1);
               end
            end
            hvm_pkg::ST_CLEAR: begin
               col_ff  <= (32'(col_ff) == TRACK_SAMPLES - 1) ? '0 : col_ff + PW'(1);
               left_ff <= left_ff - LCW'(1);
            end
            hvm_pkg::ST_EMIT: begin
               if (emit_load) begin
                  if (32'(me_ff) == MOTORS - 1) begin
                     me_ff <= '0;
                     p_ff  <= p_ff + CIW'(1);
                  end else begin
                     me_ff <= me_ff + MIW'(1);
                  end
               end
            end
            default: begin
               div_cnt_ff <= '0;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         it_v_ff     <= v_idx;
         it_m_ff     <= m_idx;
         it_level_ff <= req_level_in;
         it_scale_ff <= req_scale;
         it_off_ff   <= req_sample_offset[PW-1:0];
      end
      if (state_ff == hvm_pkg::ST_SAMP_MUL) begin
         prod_ff <= it_level_ff * $signed({1'b0, it_scale_ff});
         slot_ff <= slot_comb;
      end
      if (accept) begin
         div_quo_ff <= DW'(elapsed_ff) + DW'(req_time_delta);
         div_rem_ff <= '0;
         nmod_ff    <= '0;
      end else if (state_ff == hvm_pkg::ST_DIV_TIME) begin
         div_quo_ff <= quo_next;
         div_rem_ff <= rem_next;
         nmod_ff    <= nmod_next;
      end
      if (emit_load) begin
         rsp_phys_ff  <= 3'(p_ff);
         rsp_motor_ff <= 2'(me_ff);
         rsp_level_ff <= emit_level;
         rsp_last_ff  <= emit_last;
      end
   end

   assign req_ready          = state_ff == hvm_pkg::ST_IDLE;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_physical_index = rsp_phys_ff;
   assign rsp_motor_out      = rsp_motor_ff;
   assign rsp_drive_level    = rsp_level_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < TRACK_SAMPLES)
      else $error("ring position out of range");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      32'(left_ff) <= TRACK_SAMPLES)
      else $error("clear count beyond ring");

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hvm_pkg::ST_INIT) |-> (!rsp_valid_ff && !req_ready))
      else $error("activity during ring clear sweep");

   a_emit_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == hvm_pkg::ST_EMIT) |-> $past(state_ff == hvm_pkg::ST_READ))
      else $error("emit entered without ring read");
`endif

endmodule

// ----- sim/hvm_checker.sv -----
// checker for the vibration mixer: predicts drive levels from observed transactions and compares
`timescale 1ns / 100ps
module hvm_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [2:0]                    req_op,
   input  logic [2:0]                    req_virtual_index,
   input  logic [1:0]                    req_motor_index,
   input  logic                          req_enable_flag,
   input  logic signed [3:0]             req_physical_target,
   input  logic signed [15:0]            req_level_in,
   input  logic [15:0]                   req_scale,
   input  logic [9:0]                    req_sample_offset,
   input  logic [15:0]                   req_time_delta,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [2:0]                    rsp_physical_index,
   input  logic [1:0]                    rsp_motor_out,
   input  logic [hvm_pkg::LEVEL_W-1:0]   rsp_drive_level,
   input  logic                          rsp_last,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [hvm_pkg::PERIOD_W-1:0]  csr_sample_period,
   output int                            fail_count,
   output int                            levels_pending
);

   localparam int NC = hvm_pkg::CONTROLLERS_DEF;
   localparam int NM = hvm_pkg::MOTORS_DEF;
   localparam int NT = hvm_pkg::TRACK_SAMPLES_DEF;

   typedef struct packed {
      logic [2:0]         phys;
      logic [1:0]         motor;
      hvm_pkg::level_type level;
      logic               last;
   } drive_item;

   drive_item expected_drive[$];

   logic [hvm_pkg::PERIOD_W-1:0] period_q;
   logic                vib_on[NC];
   logic signed [3:0]   phys_map[NC];
   hvm_pkg::level_type  steady[NC][NM];
   hvm_pkg::level_type  ring[NC][NM][NT];
   int unsigned         ring_pos;
   logic [31:0]         elapsed_us;
   int                  errors = 0;

   assign fail_count = errors;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic reset_model();
      period_q   = hvm_pkg::PERIOD_W'(hvm_pkg::PERIOD_RESET);
      ring_pos   = 0;
      elapsed_us = 0;
      for (int c = 0; c < NC; c++) begin
         vib_on[c]   = 1'b0;
         phys_map[c] = 4'(c);
         for (int m = 0; m < NM; m++) begin
            steady[c][m] = '0;
            for (int s = 0; s < NT; s++) ring[c][m][s] = '0;
         end
      end
   endtask

   function automatic hvm_pkg::level_type clamp_full(input longint x);
      if (x <= 0) return '0;
      if (x >= hvm_pkg::FULL_LEVEL) return hvm_pkg::level_type'(hvm_pkg::FULL_LEVEL);
      return hvm_pkg::level_type'(x);
   endfunction

   task automatic mix_tick(input logic [15:0] delta);
      int unsigned per;
      longint unsigned steps;
      int unsigned col;
      hvm_pkg::level_type lv[NC][NM];
      hvm_pkg::level_type t;
      per = (period_q == 0) ? 1 : period_q;
      elapsed_us = elapsed_us + delta;
      steps = elapsed_us / per;
      elapsed_us = elapsed_us % per;
      for (longint unsigned k = 0; k < steps && k < NT; k++) begin
         col = (ring_pos + int'(k)) % NT;
         for (int c = 0; c < NC; c++)
            for (int m = 0; m < NM; m++) ring[c][m][col] = '0;
      end
      ring_pos = int'((longint'(ring_pos) + steps) % NT);
      for (int c = 0; c < NC; c++)
         for (int m = 0; m < NM; m++) lv[c][m] = '0;
      // higher virtual index overwrites a shared physical slot
      for (int c = 0; c < NC; c++) begin
         if (vib_on[c] && !phys_map[c][3] && int'(phys_map[c]) < NC) begin
            for (int m = 0; m < NM; m++) begin
               t = ring[c][m][ring_pos];
               lv[phys_map[c][1:0]][m] = (steady[c][m] > t) ? steady[c][m] : t;
            end
         end
      end
      for (int c = 0; c < NC; c++)
         for (int m = 0; m < NM; m++)
            expected_drive.push_back('{3'(c), 2'(m), lv[c][m],
                                       (c == NC-1) && (m == NM-1)});
   endtask

   task automatic apply_request();
      int v, m, slot;
      longint prod;
      hvm_pkg::level_type val;
      v = req_virtual_index;
      m = req_motor_index;
      if (req_op <= hvm_pkg::OP_SAMPLE && v >= NC) return;
      if ((req_op == hvm_pkg::OP_STRENGTH || req_op == hvm_pkg::OP_SAMPLE) && m >= NM) return;
      case (req_op)
         hvm_pkg::OP_ENABLE: vib_on[v] = req_enable_flag;
         hvm_pkg::OP_STRENGTH: steady[v][m] = clamp_full(longint'(req_level_in));
         hvm_pkg::OP_MAPPING: begin
            if (req_physical_target[3]) begin
               phys_map[v] = hvm_pkg::MAP_OFF;
            end else if (int'(req_physical_target) < NC) begin
               // the current holder of the target takes over the old one
               for (int c = 0; c < NC; c++) begin
                  if (phys_map[c] == req_physical_target) begin
                     phys_map[c] = phys_map[v];
                     break;
                  end
               end
               phys_map[v] = req_physical_target;
            end
         end
         hvm_pkg::OP_SAMPLE: begin
            if (req_sample_offset < NT) begin
               prod = longint'(req_level_in) * longint'({1'b0, req_scale});
               val  = (prod <= 0) ? '0 : clamp_full(prod >>> 12);
               slot = (ring_pos + 1 + req_sample_offset) % NT;
               if (val > ring[v][m][slot]) ring[v][m][slot] = val;
            end
         end
         hvm_pkg::OP_TICK: mix_tick(req_time_delta);
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         expected_drive.delete();
      end else begin
         if (csr_valid && csr_ready) period_q = csr_sample_period;
         if (req_valid && req_ready) apply_request();
         if (rsp_valid && rsp_ready) begin
            if (expected_drive.size() == 0) begin
               report_mismatch("unexpected level", rsp_drive_level, -1);
            end else begin
               drive_item want;
               want = expected_drive.pop_front();
               if (rsp_physical_index !== want.phys)
                  report_mismatch("physical_index", rsp_physical_index, want.phys);
               if (rsp_motor_out !== want.motor)
                  report_mismatch("motor_out", rsp_motor_out, want.motor);
               if (rsp_drive_level !== want.level)
                  report_mismatch("drive_level", rsp_drive_level, want.level);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
      end
      levels_pending <= expected_drive.size();
   end

endmodule

// ----- sim/testbench.sv -----
// top of the vibration mixer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module testbench;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_op = '0;
   logic [2:0]            req_virtual_index = '0;
   logic [1:0]            req_motor_index = '0;
   logic                  req_enable_flag = 1'b0;
   logic signed [3:0]     req_physical_target = '0;
   logic signed [15:0]    req_level_in = '0;
   logic [15:0]           req_scale = '0;
   logic [9:0]            req_sample_offset = '0;
   logic [15:0]           req_time_delta = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_physical_index;
   logic [1:0]            rsp_motor_out;
   logic [hvm_pkg::LEVEL_W-1:0]  rsp_drive_level;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [hvm_pkg::PERIOD_W-1:0] csr_sample_period = '0;
   int                    fail_count;
   int                    levels_pending;
   logic                  quiet = 1'b0;
   int                    stall_left = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   haptic_vibration_mixer_core i_dut (.*);

   hvm_checker i_checker (.*);

   // random stall bursts on the result side
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left == 0) begin
         rsp_ready  <= ($urandom_range(0, 2) != 0);
         stall_left <= $urandom_range(1, 16);
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   task automatic send_op(input logic [2:0] op, input logic [2:0] v, input logic [1:0] m,
                          input logic en, input logic [3:0] tgt, input logic [15:0] lvl,
                          input logic [15:0] scl, input logic [9:0] off,
                          input logic [15:0] dt);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= op;
      req_virtual_index   <= v;
      req_motor_index     <= m;
      req_enable_flag     <= en;
      req_physical_target <= tgt;
      req_level_in        <= lvl;
      req_scale           <= scl;
      req_sample_offset   <= off;
      req_time_delta      <= dt;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (levels_pending != 0) @(posedge clock);
      // ops with no levels may still be in flight
      repeat (200) @(posedge clock);
   endtask

   task automatic write_period(input logic [hvm_pkg::PERIOD_W-1:0] per);
      settle();
      csr_valid         <= 1'b1;
      csr_sample_period <= per;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_op();
      logic [2:0] op;
      logic [15:0] dt;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)      op = hvm_pkg::OP_ENABLE;
      else if (pick < 25) op = hvm_pkg::OP_STRENGTH;
      else if (pick < 35) op = hvm_pkg::OP_MAPPING;
      else if (pick < 62) op = hvm_pkg::OP_SAMPLE;
      else if (pick < 90) op = hvm_pkg::OP_TICK;
      else                op = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 2))
         0: dt = 16'($urandom);
         1: dt = 16'($urandom_range(0, 15000));
         default: dt = 16'($urandom_range(0, 200));
      endcase
      send_op(op,
              ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 3)) : 3'($urandom),
              ($urandom_range(0, 9) < 9) ? 2'($urandom_range(0, 1)) : 2'($urandom),
              ($urandom_range(0, 3) != 0),
              4'($urandom),
              $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 5000)),
              $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8192)),
              ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 3)) :
              ($urandom_range(0, 2) != 0) ? 10'($urandom_range(0, 63)) : 10'($urandom),
              dt);
   endtask

   initial begin
      logic [hvm_pkg::PERIOD_W-1:0] periods[5];
      periods = '{20'd0, 20'd1, 20'd37, 20'hFFFFF, 20'd6250};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed: reset period, extremes and ignored cases
      send_op(hvm_pkg::OP_ENABLE,   3'd0, 2'd0, 1'b1, 4'd0, 16'd0, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_ENABLE,   3'd3, 2'd0, 1'b1, 4'd0, 16'd0, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_ENABLE,   3'd7, 2'd0, 1'b1, 4'd0, 16'd0, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_STRENGTH, 3'd0, 2'd0, 1'b0, 4'd0, 16'h7FFF, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_STRENGTH, 3'd0, 2'd1, 1'b0, 4'd0, 16'h8000, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_STRENGTH, 3'd3, 2'd1, 1'b0, 4'd0, 16'd4096, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_STRENGTH, 3'd3, 2'd3, 1'b0, 4'd0, 16'd100, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_TICK,     3'd0, 2'd0, 1'b0, 4'd0, 16'd0, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_SAMPLE,   3'd3, 2'd0, 1'b0, 4'd0, 16'h7FFF, 16'hFFFF, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_SAMPLE,   3'd0, 2'd1, 1'b0, 4'd0, 16'h8000, 16'hFFFF, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_SAMPLE,   3'd3, 2'd1, 1'b0, 4'd0, 16'd2048, 16'd4096, 10'd63, 16'd0);
      send_op(hvm_pkg::OP_SAMPLE,   3'd3, 2'd1, 1'b0, 4'd0, 16'd2048, 16'd4096, 10'h3FF, 16'd0);
      send_op(hvm_pkg::OP_TICK,     3'd0, 2'd0, 1'b0, 4'd0, 16'd0, 16'd0, 10'd0, 16'd6250);
      send_op(hvm_pkg::OP_MAPPING,  3'd0, 2'd0, 1'b0, 4'd3, 16'd0, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_MAPPING,  3'd1, 2'd0, 1'b0, 4'd6, 16'd0, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_MAPPING,  3'd3, 2'd0, 1'b0, 4'hF, 16'd0, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_MAPPING,  3'd6, 2'd0, 1'b0, 4'd1, 16'd0, 16'd0, 10'd0, 16'd0);
      send_op(3'd5,                 3'd0, 2'd0, 1'b0, 4'd0, 16'd0, 16'd0, 10'd0, 16'd0);
      send_op(3'd7,                 3'd7, 2'd3, 1'b1, 4'hF, 16'hFFFF, 16'hFFFF, 10'h3FF,
              16'hFFFF);
      send_op(hvm_pkg::OP_TICK,     3'd0, 2'd0, 1'b0, 4'd0, 16'd0, 16'd0, 10'd0, 16'hFFFF);
      send_op(hvm_pkg::OP_ENABLE,   3'd3, 2'd0, 1'b0, 4'd0, 16'd0, 16'd0, 10'd0, 16'd0);
      send_op(hvm_pkg::OP_TICK,     3'd0, 2'd0, 1'b0, 4'd0, 16'd0, 16'd0, 10'd0, 16'd1);
      for (int ph = 0; ph < 5; ph++) begin
         write_period(periods[ph]);
         if (ph == 4) quiet <= 1'b1;
         for (int i = 0; i < 32; i++) send_random_op();
      end
      settle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(12 * 1000000);
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
